FILE: hw/rtl/lfps_pkg.sv
`timescale 1ns / 1ps
package lfps_pkg;

  localparam int BRIGHT_W = 7;
  localparam int PWM_W    = 8;
  localparam int GAIN_W   = 24;
  localparam int ERR_W    = 8;
  localparam int DELTA_W  = 9;
  // integral operand is held to +-2^32, far past where the drive saturates
  localparam int ISUM_W   = 34;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  typedef logic        [BRIGHT_W-1:0] bright_t;
  typedef logic signed [PWM_W-1:0]    pwm_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;
  typedef logic signed [ERR_W-1:0]    err_t;
  typedef logic signed [DELTA_W-1:0]  delta_t;
  typedef logic signed [ISUM_W-1:0]   isum_t;

  typedef enum logic [2:0] {
    REG_SETPOINT = 3'd0,
    REG_P_GAIN   = 3'd1,
    REG_I_GAIN   = 3'd2,
    REG_D_GAIN   = 3'd3,
    REG_BASE_PWM = 3'd4
  } reg_idx_t;

  localparam bright_t SETPOINT_RESET = 7'd11;

  typedef struct packed {
    bright_t setpoint;
    gain_t   p_gain;
    gain_t   i_gain;
    gain_t   d_gain;
    pwm_t    base_pwm;
  } lfps_cfg_t;

  // one classified sample handed from front to back
  typedef struct packed {
    err_t   err;
    delta_t delta;
    isum_t  isum;
    logic   steer_right;
  } lfps_job_t;

endpackage

FILE: hw/rtl/lfps_sample_if.sv
`timescale 1ns / 1ps
interface lfps_sample_if import lfps_pkg::*; ();
  logic    valid;
  logic    ready;
  bright_t brightness;

  modport source (output valid, output brightness, input ready);
  modport sink (input valid, input brightness, output ready);
endinterface

FILE: hw/rtl/lfps_steer_if.sv
`timescale 1ns / 1ps
interface lfps_steer_if import lfps_pkg::*; ();
  logic valid;
  logic ready;
  pwm_t right_pwm;
  pwm_t left_pwm;

  modport source (output valid, output right_pwm, output left_pwm, input ready);
  modport sink (input valid, input right_pwm, input left_pwm, output ready);
endinterface

FILE: hw/rtl/lfps_front.sv
`timescale 1ns / 1ps
module lfps_front import lfps_pkg::*; #(
  parameter int SUM_WIDTH = 24
) (
  input  logic              clk,
  input  logic              rst,
  lfps_sample_if.sink       sample,
  input  bright_t           setpoint,
  output logic              push_valid,
  input  logic              push_ready,
  output lfps_job_t         push_job
);

  localparam int SW = SUM_WIDTH;
  localparam int EW = (SW > ISUM_W) ? SW : ISUM_W;
  localparam logic signed [SW+1:0] SMAX = {3'b000, {(SW-1){1'b1}}};
  localparam logic signed [SW+1:0] SMIN = -SMAX - 1;
  localparam logic signed [EW-1:0] IPOS = {{(EW-33){1'b0}}, 1'b1, 32'b0};
  localparam logic signed [EW-1:0] INEG = -IPOS;

  err_t                   last_error;
  logic signed [SW-1:0]   error_sum;

  err_t                   err;
  logic signed [SW+1:0]   sum_wide;
  logic signed [SW-1:0]   sum_next;
  logic signed [EW-1:0]   sum_ext;
  isum_t                  isum;
  logic                   accept;

  assign accept       = sample.valid && push_ready;
  assign sample.ready = push_ready;

  assign err = err_t'({1'b0, setpoint}) - err_t'({1'b0, sample.brightness});

  always_comb begin
    sum_wide = (SW+2)'(error_sum) + (SW+2)'(err) + (SW+2)'(last_error);
    if (sum_wide > SMAX) begin
      sum_next = SW'(SMAX);
    end else if (sum_wide < SMIN) begin
      sum_next = SW'(SMIN);
    end else begin
      sum_next = SW'(sum_wide);
    end
    sum_ext = EW'(sum_next);
    if (sum_ext > IPOS) begin
      isum = ISUM_W'(IPOS);
    end else if (sum_ext < INEG) begin
      isum = ISUM_W'(INEG);
    end else begin
      isum = ISUM_W'(sum_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum  <= '0;
    end else if (accept) begin
      last_error <= err;
      error_sum  <= sum_next;
    end
  end

  assign push_valid            = sample.valid;
  assign push_job.err          = err;
  assign push_job.delta        = delta_t'(err) - delta_t'(last_error);
  assign push_job.isum         = isum;
  // error below setpoint is the same as any light seen at all
  assign push_job.steer_right  = (sample.brightness != '0);

endmodule

FILE: hw/rtl/lfps_queue.sv
`timescale 1ns / 1ps
module lfps_queue import lfps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  lfps_job_t push_job,
  output logic      pop_valid,
  input  logic      pop_ready,
  output lfps_job_t pop_job
);

  lfps_job_t  slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/lfps_back.sv
`timescale 1ns / 1ps
module lfps_back import lfps_pkg::*; #(
  parameter int PWM_LIMIT = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  lfps_cfg_t   cfg,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  lfps_job_t   pop_job,
  lfps_steer_if.source steer
);

  localparam int PW = 32;
  localparam int DW = 33;
  localparam int IW = GAIN_W + ISUM_W;
  localparam int TW = 36;
  localparam int MW = TW - 16;
  localparam logic signed [IW-1:0] IPOS = IW'(64'sd4294967296);
  localparam logic signed [IW-1:0] INEG = -IPOS;
  localparam logic [MW-1:0]        MAG_LIM = MW'(PWM_LIMIT);
  localparam logic signed [8:0]    LIM_POS = 9'(PWM_LIMIT);
  localparam logic signed [8:0]    LIM_NEG = -LIM_POS;

  // stage 1: products
  logic                  v1;
  logic signed [PW-1:0]  p1;
  logic signed [DW-1:0]  d1;
  logic signed [IW-1:0]  i1;
  logic                  r1;
  // stage 2: sum of terms
  logic                  v2;
  logic signed [TW-1:0]  total2;
  logic                  r2;
  // stage 3: rounded, saturated drive
  logic                  v3;
  pwm_t                  drive3;
  logic                  r3;
  // output word
  logic                  vo;
  pwm_t                  right_pwm;
  pwm_t                  left_pwm;

  logic adv1, adv2, adv3, advo;

  logic signed [ISUM_W-1:0] i_cl;
  logic        [TW-1:0]     tot_mag;
  logic        [MW-1:0]     mag;
  pwm_t                     mag_sat;
  logic signed [8:0]        base9;
  logic signed [8:0]        base_cl;
  logic signed [8:0]        moved;
  logic signed [8:0]        moved_cl;

  assign advo      = !vo || steer.ready;
  assign adv3      = !v3 || advo;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign pop_ready = adv1;

  always_comb begin
    if (i1 > IPOS) begin
      i_cl = ISUM_W'(IPOS);
    end else if (i1 < INEG) begin
      i_cl = ISUM_W'(INEG);
    end else begin
      i_cl = ISUM_W'(i1);
    end
  end

  always_comb begin
    tot_mag = total2[TW-1] ? TW'(-total2) : TW'(total2);
    mag     = MW'((tot_mag + TW'(32768)) >> 16);
    mag_sat = (mag > MAG_LIM) ? pwm_t'(MAG_LIM) : pwm_t'(mag);
  end

  always_comb begin
    base9 = 9'(cfg.base_pwm);
    if (base9 > LIM_POS) begin
      base_cl = LIM_POS;
    end else if (base9 < LIM_NEG) begin
      base_cl = LIM_NEG;
    end else begin
      base_cl = base9;
    end
    moved = base_cl + 9'(drive3);
    if (moved > LIM_POS) begin
      moved_cl = LIM_POS;
    end else if (moved < LIM_NEG) begin
      moved_cl = LIM_NEG;
    end else begin
      moved_cl = moved;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      p1 <= PW'(cfg.p_gain) * PW'(pop_job.err);
      d1 <= DW'(cfg.d_gain) * DW'(pop_job.delta);
      i1 <= IW'(cfg.i_gain) * IW'(pop_job.isum);
      r1 <= pop_job.steer_right;
    end
    if (adv2) begin
      total2 <= TW'(p1) + TW'(d1) + TW'(i_cl);
      r2     <= r1;
    end
    if (adv3) begin
      drive3 <= total2[TW-1] ? -mag_sat : mag_sat;
      r3     <= r2;
    end
    if (advo) begin
      right_pwm <= r3 ? PWM_W'(moved_cl) : PWM_W'(base_cl);
      left_pwm  <= r3 ? PWM_W'(base_cl) : PWM_W'(moved_cl);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= pop_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
      if (advo) begin
        vo <= v3;
      end
    end
  end

  assign steer.valid     = vo;
  assign steer.right_pwm = right_pwm;
  assign steer.left_pwm  = left_pwm;

endmodule

FILE: hw/rtl/line_follow_pid_steering_unit.sv
`timescale 1ns / 1ps
// Line-follow PID steering: each brightness word on sample gives one word of
// right/left motor PWM on steer. Error is setpoint - brightness; a trapezoidal
// integral (sum of current and previous error, saturating at SUM_WIDTH bits)
// and the error difference feed P+I+D with Q8.16 gains, rounded to nearest and
// held to +-PWM_LIMIT. With any light seen the right motor gets base+drive and
// the left base, otherwise the other way round. One word is taken every clock
// while the queue has room; that rate is set by the integral update in the
// front end, which registers each new sum as its word is taken. Each result
// passes queue, multiply, sum, round and output registers. Registers sit on
// an APB port at byte offsets 0x00 setpoint, 0x04 p_gain, 0x08 i_gain, 0x0C
// d_gain, 0x10 base_pwm; write them only while the unit is idle.
module line_follow_pid_steering_unit import lfps_pkg::*; #(
  parameter int PWM_LIMIT = 100,
  parameter int SUM_WIDTH = 24
) (
  input  logic              clk,
  input  logic              rst,
  lfps_sample_if.sink       sample,
  lfps_steer_if.source      steer,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  lfps_cfg_t cfg;
  reg_idx_t  reg_sel;
  logic      wr_en;

  logic      push_valid;
  logic      push_ready;
  lfps_job_t push_job;
  logic      pop_valid;
  logic      pop_ready;
  lfps_job_t pop_job;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint <= SETPOINT_RESET;
      cfg.p_gain   <= '0;
      cfg.i_gain   <= '0;
      cfg.d_gain   <= '0;
      cfg.base_pwm <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SETPOINT: cfg.setpoint <= pwdata[BRIGHT_W-1:0];
        REG_P_GAIN:   cfg.p_gain   <= pwdata[GAIN_W-1:0];
        REG_I_GAIN:   cfg.i_gain   <= pwdata[GAIN_W-1:0];
        REG_D_GAIN:   cfg.d_gain   <= pwdata[GAIN_W-1:0];
        REG_BASE_PWM: cfg.base_pwm <= pwdata[PWM_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SETPOINT: prdata = DATA_W'(cfg.setpoint);
      REG_P_GAIN:   prdata = DATA_W'(cfg.p_gain);
      REG_I_GAIN:   prdata = DATA_W'(cfg.i_gain);
      REG_D_GAIN:   prdata = DATA_W'(cfg.d_gain);
      REG_BASE_PWM: prdata = DATA_W'(cfg.base_pwm);
      default:      prdata = '0;
    endcase
  end

  lfps_front #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .setpoint   (cfg.setpoint),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  lfps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  lfps_back #(
    .PWM_LIMIT (PWM_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .steer     (steer)
  );

`ifndef SYNTHESIS
  localparam logic signed [7:0] LIM_P = 8'(PWM_LIMIT);
  localparam logic signed [7:0] LIM_N = -LIM_P;

  a_right_range: assert property (@(posedge clk) disable iff (rst)
    steer.valid |-> (steer.right_pwm <= LIM_P && steer.right_pwm >= LIM_N))
    else $error("right pwm outside limit");

  a_left_range: assert property (@(posedge clk) disable iff (rst)
    steer.valid |-> (steer.left_pwm <= LIM_P && steer.left_pwm >= LIM_N))
    else $error("left pwm outside limit");

  // nothing can reach the output register in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !steer.valid)
    else $error("result word straight after reset");

  // the queue only refuses while it is holding words for the back end
  a_queue_drain: assert property (@(posedge clk) disable iff (rst)
    !push_ready |-> pop_valid)
    else $error("queue full but empty to the back end");
`endif

endmodule

FILE: test/line_follow_pid_steering_unit_tb.sv
`timescale 1ns / 1ps
module line_follow_pid_steering_unit_tb;
  import lfps_pkg::*;

  localparam int     PWM_LIMIT    = 100;
  localparam int     SUM_WIDTH    = 24;
  localparam longint SUM_MAX      = (longint'(1) << (SUM_WIDTH - 1)) - 1;
  localparam longint SUM_MIN      = -SUM_MAX - 1;
  localparam longint ITERM_LIM    = longint'(1) << 40;
  localparam longint HALF_LSB     = longint'(1) << 15;
  localparam int     FRAC_BITS    = 16;
  localparam int     DRAIN_PAD    = 16;
  localparam int     CYCLE_LIMIT  = 1000000;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     WINDUP_ITEMS = 40;
  localparam int     PHASE_ITEMS  = 165;
  localparam int     REG_SLOTS    = 1 << $bits(reg_idx_t);
  localparam int     SPARE_FIRST  = int'(REG_BASE_PWM) + 1;

  localparam bright_t BRIGHT_TOP  = '1;
  localparam gain_t   GAIN_ONE    = 24'sd65536;
  localparam gain_t   GAIN_HALF   = 24'sd32768;
  localparam gain_t   GAIN_MAX    = 24'sh7FFFFF;
  localparam gain_t   GAIN_MIN    = 24'sh800000;
  localparam gain_t   GAIN_LSB    = 24'sd1;
  // integral drive climbs by about four per full-scale sample
  localparam gain_t   GAIN_WINDUP = 24'sd1024;

  typedef struct packed {
    pwm_t right_pwm;
    pwm_t left_pwm;
  } steer_word_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lfps_sample_if sample_ch ();
  lfps_steer_if  steer_ch ();

  line_follow_pid_steering_unit #(
    .PWM_LIMIT(PWM_LIMIT),
    .SUM_WIDTH(SUM_WIDTH)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch.sink),
    .steer  (steer_ch.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // shadow registers and controller state
  bright_t cfg_setpoint = SETPOINT_RESET;
  gain_t   cfg_p_gain   = '0;
  gain_t   cfg_i_gain   = '0;
  gain_t   cfg_d_gain   = '0;
  pwm_t    cfg_base     = '0;
  longint  err_acc      = 0;
  longint  last_err     = 0;

  steer_word_t expected_steer[$];

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_left     = 0;
  int mismatches    = 0;
  int samples_sent  = 0;
  int words_seen    = 0;
  int reg_writes    = 0;
  int cycles        = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint bound(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic steer_word_t predict_steer(input bright_t b);
    longint      err, iterm, total, mag, drive, base, right, left;
    steer_word_t w;
    err     = longint'(cfg_setpoint) - longint'(b);
    err_acc = bound(err_acc + err + last_err, SUM_MIN, SUM_MAX);
    iterm   = bound(longint'(cfg_i_gain) * err_acc, -ITERM_LIM, ITERM_LIM);
    total   = longint'(cfg_p_gain) * err + iterm + longint'(cfg_d_gain) * (err - last_err);
    mag     = ((total < 0 ? -total : total) + HALF_LSB) >> FRAC_BITS;
    if (mag > PWM_LIMIT) mag = PWM_LIMIT;
    drive = total < 0 ? -mag : mag;
    base  = bound(longint'(cfg_base), -PWM_LIMIT, PWM_LIMIT);
    // any light seen steers through the right motor
    if (err < longint'(cfg_setpoint)) begin
      right = bound(base + drive, -PWM_LIMIT, PWM_LIMIT);
      left  = base;
    end else begin
      right = base;
      left  = bound(base + drive, -PWM_LIMIT, PWM_LIMIT);
    end
    last_err    = err;
    w.right_pwm = pwm_t'(right);
    w.left_pwm  = pwm_t'(left);
    return w;
  endfunction

  task automatic send_sample(input bright_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      sample_ch.valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    sample_ch.valid      = 1'b1;
    sample_ch.brightness = b;
    do @(posedge clk); while (!sample_ch.ready);
    expected_steer.push_back(predict_steer(b));
    samples_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    sample_ch.valid = 1'b0;
    while (expected_steer.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SETPOINT: cfg_setpoint = value[BRIGHT_W-1:0];
      REG_P_GAIN:   cfg_p_gain   = value[GAIN_W-1:0];
      REG_I_GAIN:   cfg_i_gain   = value[GAIN_W-1:0];
      REG_D_GAIN:   cfg_d_gain   = value[GAIN_W-1:0];
      REG_BASE_PWM: cfg_base     = value[PWM_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // junk in the unused upper bits of each write
  task automatic set_config(input bright_t sp, input gain_t p, input gain_t i, input gain_t d,
                            input pwm_t base);
    wait_drain();
    repeat (DRAIN_PAD) @(posedge clk);
    write_reg(REG_SETPOINT, {(DATA_W - BRIGHT_W)'($urandom), sp});
    write_reg(REG_P_GAIN, {(DATA_W - GAIN_W)'($urandom), p});
    write_reg(REG_I_GAIN, {(DATA_W - GAIN_W)'($urandom), i});
    write_reg(REG_D_GAIN, {(DATA_W - GAIN_W)'($urandom), d});
    write_reg(REG_BASE_PWM, {(DATA_W - PWM_W)'($urandom), base});
  endtask

  function automatic gain_t random_gain(input int span_bits);
    int mag;
    mag = int'($urandom_range(1 << span_bits));
    case ($urandom_range(7))
      0: return gain_t'($urandom);
      1: return '0;
      default: return ($urandom_range(1) != 0) ? gain_t'(-mag) : gain_t'(mag);
    endcase
  endfunction

  function automatic bright_t random_brightness();
    int v;
    v = int'(cfg_setpoint) + int'($urandom_range(40)) - 20;
    case ($urandom_range(9))
      0: return '0;
      1, 2: return bright_t'($urandom);
      default: return bright_t'(bound(v, 0, int'(BRIGHT_TOP)));
    endcase
  endfunction

  task automatic test_reset_values();
    send_sample('0);
    send_sample(BRIGHT_TOP);
    send_sample(SETPOINT_RESET);
  endtask

  task automatic test_directed_cases();
    set_config(7'd50, GAIN_ONE, '0, '0, '0);
    send_sample(7'd0);
    send_sample(7'd50);
    send_sample(7'd100);
    send_sample(BRIGHT_TOP);
    // half gain puts odd errors on rounding ties
    set_config(7'd50, GAIN_HALF, '0, '0, '0);
    send_sample(7'd49);
    send_sample(7'd51);
    send_sample(7'd47);
    send_sample(7'd53);
    set_config(7'd50, '0, '0, GAIN_ONE, '0);
    send_sample(7'd50);
    send_sample(7'd40);
    send_sample(7'd60);
    set_config(BRIGHT_TOP, GAIN_MAX, '0, '0, 8'sh7F);
    send_sample(7'd0);
    send_sample(BRIGHT_TOP);
    set_config('0, GAIN_MIN, '0, '0, 8'sh80);
    send_sample(7'd0);
    send_sample(BRIGHT_TOP);
    set_config(7'd100, '0, GAIN_MAX, GAIN_MIN, 8'sd100);
    // unmapped slots must leave the registers alone
    for (int k = SPARE_FIRST; k < REG_SLOTS; k++) write_reg(3'(k), $urandom);
    send_sample(7'd100);
    send_sample(7'd0);
  endtask

  task automatic test_integral_windup();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    set_config(BRIGHT_TOP, '0, GAIN_WINDUP, '0, '0);
    repeat (WINDUP_ITEMS) send_sample('0);
    set_config('0, '0, GAIN_WINDUP, '0, '0);
    repeat (2 * WINDUP_ITEMS) send_sample(BRIGHT_TOP);
    // walk the integral back to the middle
    set_config(BRIGHT_TOP, random_gain(17), GAIN_LSB, random_gain(17), '0);
    while (err_acc < 0) send_sample('0);
  endtask

  task automatic test_fill_and_drain();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    set_config(7'd60, GAIN_ONE, random_gain(10), GAIN_HALF, -8'sd20);
    hold_left = HOLD_CYCLES;
    repeat (40) send_sample(random_brightness());
    wait_drain();
    hold_left = HOLD_CYCLES / 2;
    repeat (20) send_sample(random_brightness());
    wait_drain();
  endtask

  task automatic test_random_phases();
    int src_pct[4];
    int snk_pct[4];
    src_pct = '{0, 81, 0, 31};
    snk_pct = '{0, 0, 81, 31};
    for (int m = 0; m < 4; m++) begin
      for (int s = 0; s < 2; s++) begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        set_config(($urandom_range(3) == 0) ? bright_t'($urandom) : bright_t'($urandom_range(100)),
                   random_gain(17), random_gain(10), random_gain(17),
                   ($urandom_range(3) == 0) ? pwm_t'($urandom)
                                            : pwm_t'(int'($urandom_range(120)) - 60));
        src_idle_pct  = src_pct[m];
        snk_stall_pct = snk_pct[m];
        repeat (PHASE_ITEMS) begin
          send_sample(random_brightness());
          if ($urandom_range(63) == 0) wait_drain();
        end
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      steer_ch.ready = 1'b0;
      hold_left--;
    end else begin
      steer_ch.ready = ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin : check_steer
    steer_word_t want;
    if (!rst && steer_ch.valid && steer_ch.ready) begin
      words_seen++;
      if (expected_steer.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected steer word right %0d left %0d", $time,
                 steer_ch.right_pwm, steer_ch.left_pwm);
      end else begin
        want = expected_steer.pop_front();
        if (steer_ch.right_pwm !== want.right_pwm) begin
          mismatches++;
          $display("%0t: right_pwm expected %0d got %0d", $time, want.right_pwm,
                   steer_ch.right_pwm);
        end
        if (steer_ch.left_pwm !== want.left_pwm) begin
          mismatches++;
          $display("%0t: left_pwm expected %0d got %0d", $time, want.left_pwm,
                   steer_ch.left_pwm);
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timed out with %0d words outstanding", $time, expected_steer.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst                  = 1'b1;
    sample_ch.valid      = 1'b0;
    sample_ch.brightness = '0;
    steer_ch.ready       = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_directed_cases();
    test_integral_windup();
    test_fill_and_drain();
    test_random_phases();

    wait_drain();
    repeat (DRAIN_PAD) @(posedge clk);
    if (expected_steer.size() != 0) begin
      mismatches += expected_steer.size();
      $display("%0t: %0d steer words never arrived", $time, expected_steer.size());
    end
    $display("covered %0d samples, %0d steer words and %0d register writes", samples_sent,
             words_seen, reg_writes);
    $display("integral wound up both ways; four idling patterns and a long output hold-off");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
